@@ hw/rtl/esg_pkg.sv @@
// Shared types, widths and codes of the ellipse span generator.
package esg_pkg;

   // Field widths
   localparam int CENTER_W    = 14;
   localparam int RADIUS_IN_W = 11;
   localparam int RADIUS_W    = 12;
   localparam int SCALE_W     = 9;
   localparam int SCREEN_W    = 12;
   localparam int SQ_W        = 23;
   localparam int TERM_W      = 45;
   localparam int PROD_W      = 2 * SQ_W;
   localparam int ROW_W       = 15;
   localparam int SLOPE_W     = 13;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Stream payload widths
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_TUSER_W = 2;

   localparam logic [SCALE_W-1:0] SCALE_ONE = 9'd256;

   // Input item kinds
   localparam logic MODE_START   = 1'b0;
   localparam logic MODE_ADVANCE = 1'b1;

   // Register indexes, taken from paddr bit 2
   localparam logic REG_SCREEN_WIDTH  = 1'b0;
   localparam logic REG_SCREEN_HEIGHT = 1'b1;

   localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RESET  = 12'd800;
   localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RESET = 12'd600;

   // Shared multiplier operations
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_HH,
      MUL_WW,
      MUL_BOUND,
      MUL_YY,
      MUL_YTERM,
      MUL_XX,
      MUL_XTERM
   } mul_op_type;

   // Result register loads
   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_CENTER,
      EMIT_UP,
      EMIT_DOWN
   } emit_type;

   typedef struct packed {
      logic       capture;
      logic       load_start;
      logic       adv_init;
      mul_op_type mul_op;
      logic       step_down;
      logic       finish;
      emit_type   emit;
   } esg_cmd_type;

   typedef struct packed {
      logic is_start;
      logic active;
      logic x_zero;
      logic test_pass;
      logic out_free;
   } esg_status_type;

endpackage

@@ hw/rtl/esg_ctrl.sv @@
// Sequencer of the ellipse span generator: start setup, row search, span output.
module esg_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  esg_pkg::esg_status_type status,
   output esg_pkg::esg_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_HH,
      ST_WW,
      ST_BOUND,
      ST_EMIT_C,
      ST_YY,
      ST_YTERM,
      ST_XX,
      ST_XTERM,
      ST_TEST,
      ST_FINISH,
      ST_EMIT_UP,
      ST_EMIT_DN
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Decode the state into datapath commands and pick the next state
   always_comb begin
      cmd        = '0;
      cmd.mul_op = esg_pkg::MUL_NONE;
      cmd.emit   = esg_pkg::EMIT_NONE;
      state_in   = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_start) begin
               cmd.load_start = 1'b1;
               state_in       = ST_HH;
            end else if (status.active) begin
               cmd.adv_init = 1'b1;
               state_in     = ST_YY;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_HH: begin
            cmd.mul_op = esg_pkg::MUL_HH;
            state_in   = ST_WW;
         end
         ST_WW: begin
            cmd.mul_op = esg_pkg::MUL_WW;
            state_in   = ST_BOUND;
         end
         ST_BOUND: begin
            cmd.mul_op = esg_pkg::MUL_BOUND;
            state_in   = ST_EMIT_C;
         end
         ST_EMIT_C: begin
            if (status.out_free) begin
               cmd.emit = esg_pkg::EMIT_CENTER;
               state_in = ST_IDLE;
            end
         end
         ST_YY: begin
            cmd.mul_op = esg_pkg::MUL_YY;
            state_in   = ST_YTERM;
         end
         ST_YTERM: begin
            cmd.mul_op = esg_pkg::MUL_YTERM;
            state_in   = ST_XX;
         end
         ST_XX: begin
            if (status.x_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.mul_op = esg_pkg::MUL_XX;
               state_in   = ST_XTERM;
            end
         end
         ST_XTERM: begin
            cmd.mul_op = esg_pkg::MUL_XTERM;
            state_in   = ST_TEST;
         end
         ST_TEST: begin
            if (status.test_pass) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step_down = 1'b1;
               state_in      = ST_XX;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_EMIT_UP;
         end
         ST_EMIT_UP: begin
            if (status.out_free) begin
               cmd.emit = esg_pkg::EMIT_UP;
               state_in = ST_EMIT_DN;
            end
         end
         ST_EMIT_DN: begin
            if (status.out_free) begin
               cmd.emit = esg_pkg::EMIT_DOWN;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/esg_datapath.sv @@
// Datapath of the ellipse span generator: shape registers, multiplier, clipping, result register.
module esg_datapath #(
   parameter int RADIUS_MARGIN = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  esg_pkg::esg_cmd_type                 cmd,
   output esg_pkg::esg_status_type              status,
   input  logic [esg_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  logic                                 req_tuser,
   input  logic [esg_pkg::SCREEN_W-1:0]         screen_width,
   input  logic [esg_pkg::SCREEN_W-1:0]         screen_height,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [esg_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic [esg_pkg::RSP_TUSER_W-1:0]      rsp_tuser,
   output logic                                 rsp_tlast
);

   localparam int CW = esg_pkg::CENTER_W;
   localparam int RW = esg_pkg::RADIUS_W;
   localparam int IW = esg_pkg::RADIUS_IN_W;
   localparam int SW = esg_pkg::SCALE_W;
   localparam int QW = esg_pkg::SQ_W;
   localparam int TW = esg_pkg::TERM_W;
   localparam int PW = esg_pkg::PROD_W;
   localparam int OW = esg_pkg::ROW_W;
   localparam int DW = esg_pkg::SLOPE_W;
   localparam int XW = esg_pkg::SCREEN_W;
   localparam logic [RW-1:0] MARGIN = RADIUS_MARGIN[RW-1:0];

   // Captured input transaction
   logic          in_mode_ff;
   logic [CW-1:0] in_cx_ff, in_cy_ff;
   logic [IW-1:0] in_hw_ff, in_hh_ff;
   logic [SW-1:0] in_scale_ff;

   // Ellipse state
   logic signed [CW-1:0] center_col_ff, center_col_in;
   logic signed [CW-1:0] center_row_ff, center_row_in;
   logic [RW-1:0] full_hw_ff, full_hw_in;
   logic [RW-1:0] full_hh_ff, full_hh_in;
   logic [QW-1:0] hsq_ff, hsq_in;
   logic [QW-1:0] wsq_ff, wsq_in;
   logic [TW-1:0] bound_ff, bound_in;
   logic [QW-1:0] tmp_ff, tmp_in;
   logic [TW-1:0] yterm_ff, yterm_in;
   logic [TW-1:0] xterm_ff, xterm_in;
   logic [RW-1:0] row_off_ff, row_off_in;
   logic [RW-1:0] half_span_ff, half_span_in;
   logic signed [DW-1:0] slope_ff, slope_in;
   logic [RW-1:0] trial_x_ff, trial_x_in;
   logic [RW-1:0] trial_y_ff, trial_y_in;
   logic [SW-1:0] scale_ff, scale_in;
   logic          active_ff, active_in;
   logic          done_ff, done_in;

   // Result register
   logic          out_valid_ff, out_valid_in;
   logic [XW-1:0] out_row_ff, out_row_in;
   logic [XW-1:0] out_first_ff, out_first_in;
   logic [XW-1:0] out_final_ff, out_final_in;
   logic          out_vis_ff, out_vis_in;
   logic [SW-1:0] out_scale_ff, out_scale_in;
   logic          out_last_ff, out_last_in;
   logic          out_done_ff, out_done_in;

   // Shared multiplier
   logic [QW-1:0] mul_a, mul_b;
   logic [PW-1:0] mul_p;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_op)
         esg_pkg::MUL_HH: begin
            mul_a = {{(QW-RW){1'b0}}, full_hh_ff};
            mul_b = {{(QW-RW){1'b0}}, full_hh_ff};
         end
         esg_pkg::MUL_WW: begin
            mul_a = {{(QW-RW){1'b0}}, full_hw_ff};
            mul_b = {{(QW-RW){1'b0}}, full_hw_ff};
         end
         esg_pkg::MUL_BOUND: begin
            mul_a = hsq_ff;
            mul_b = wsq_ff;
         end
         esg_pkg::MUL_YY: begin
            mul_a = {{(QW-RW){1'b0}}, trial_y_ff};
            mul_b = {{(QW-RW){1'b0}}, trial_y_ff};
         end
         esg_pkg::MUL_YTERM: begin
            mul_a = tmp_ff;
            mul_b = wsq_ff;
         end
         esg_pkg::MUL_XX: begin
            mul_a = {{(QW-RW){1'b0}}, trial_x_ff};
            mul_b = {{(QW-RW){1'b0}}, trial_x_ff};
         end
         esg_pkg::MUL_XTERM: begin
            mul_a = tmp_ff;
            mul_b = hsq_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Ellipse test: x*x*hh + y*y*ww <= hh*ww
   logic [TW:0] test_sum;
   assign test_sum = {1'b0, xterm_ff} + {1'b0, yterm_ff};

   // Search start: previous half-span minus slope plus one, clamped to 0 .. w+1
   logic signed [OW-1:0] start_s, start_lim;
   logic [RW-1:0]        start_x;
   assign start_s   = $signed({{(OW-RW){1'b0}}, half_span_ff})
                    - $signed({{(OW-DW){slope_ff[DW-1]}}, slope_ff})
                    + OW'(1);
   assign start_lim = $signed({{(OW-RW){1'b0}}, full_hw_ff}) + OW'(1);

   always_comb begin
      if (start_s > start_lim) begin
         start_x = start_lim[RW-1:0];
      end else if (start_s < 0) begin
         start_x = '0;
      end else begin
         start_x = start_s[RW-1:0];
      end
   end

   // Start transaction fields
   logic [RW-1:0] start_w, start_h;
   logic [SW-1:0] start_scale;
   assign start_w     = {1'b0, in_hw_ff} + MARGIN;
   assign start_h     = {1'b0, in_hh_ff} + MARGIN;
   assign start_scale = (in_scale_ff > esg_pkg::SCALE_ONE) ? esg_pkg::SCALE_ONE : in_scale_ff;

   // Span selection and clipping
   logic signed [OW-1:0] span_row, span_first, span_final, first_c, final_c, col_lim;
   logic signed [OW-1:0] center_ext, row_ext, off_ext, half_ext;
   logic [RW-1:0]        span_half;
   logic                 span_last, span_vis;

   assign center_ext = {{(OW-CW){center_col_ff[CW-1]}}, center_col_ff};
   assign row_ext    = {{(OW-CW){center_row_ff[CW-1]}}, center_row_ff};
   assign off_ext    = $signed({{(OW-RW){1'b0}}, row_off_ff});

   always_comb begin
      case (cmd.emit)
         esg_pkg::EMIT_UP: begin
            span_row  = row_ext - off_ext;
            span_half = half_span_ff;
            span_last = 1'b0;
         end
         esg_pkg::EMIT_DOWN: begin
            span_row  = row_ext + off_ext;
            span_half = half_span_ff;
            span_last = 1'b1;
         end
         default: begin
            span_row  = row_ext;
            span_half = full_hw_ff;
            span_last = 1'b1;
         end
      endcase
   end

   assign half_ext   = $signed({{(OW-RW){1'b0}}, span_half});
   assign span_first = center_ext - half_ext;
   assign span_final = center_ext + half_ext;
   assign col_lim    = $signed({{(OW-XW){1'b0}}, screen_width}) - OW'(1);
   assign first_c    = (span_first < 0) ? '0 : span_first;
   assign final_c    = (span_final > col_lim) ? col_lim : span_final;
   assign span_vis   = (span_row >= 0)
                    && (span_row < $signed({{(OW-XW){1'b0}}, screen_height}))
                    && (first_c <= final_c);

   // Next state of the ellipse registers
   always_comb begin
      center_col_in = center_col_ff;
      center_row_in = center_row_ff;
      full_hw_in    = full_hw_ff;
      full_hh_in    = full_hh_ff;
      hsq_in        = hsq_ff;
      wsq_in        = wsq_ff;
      bound_in      = bound_ff;
      tmp_in        = tmp_ff;
      yterm_in      = yterm_ff;
      xterm_in      = xterm_ff;
      row_off_in    = row_off_ff;
      half_span_in  = half_span_ff;
      slope_in      = slope_ff;
      trial_x_in    = trial_x_ff;
      trial_y_in    = trial_y_ff;
      scale_in      = scale_ff;
      active_in     = active_ff;
      done_in       = done_ff;

      // Latch a new ellipse, dropping any one in progress
      if (cmd.load_start) begin
         center_col_in = $signed(in_cx_ff);
         center_row_in = $signed(in_cy_ff);
         full_hw_in    = start_w;
         full_hh_in    = start_h;
         row_off_in    = '0;
         half_span_in  = start_w;
         slope_in      = '0;
         scale_in      = start_scale;
         done_in       = (start_h == '0);
         active_in     = (start_h != '0);
      end

      // Step one row outward and seed the search
      if (cmd.adv_init) begin
         trial_y_in = row_off_ff + RW'(1);
         trial_x_in = start_x;
      end

      case (cmd.mul_op)
         esg_pkg::MUL_HH:    hsq_in   = mul_p[QW-1:0];
         esg_pkg::MUL_WW:    wsq_in   = mul_p[QW-1:0];
         esg_pkg::MUL_BOUND: bound_in = mul_p[TW-1:0];
         esg_pkg::MUL_YY:    tmp_in   = mul_p[QW-1:0];
         esg_pkg::MUL_YTERM: yterm_in = mul_p[TW-1:0];
         esg_pkg::MUL_XX:    tmp_in   = mul_p[QW-1:0];
         esg_pkg::MUL_XTERM: xterm_in = mul_p[TW-1:0];
         default: begin
            tmp_in = tmp_ff;
         end
      endcase

      if (cmd.step_down) begin
         trial_x_in = trial_x_ff - RW'(1);
      end

      // Commit the row: new slope, half-span, offset and done flag
      if (cmd.finish) begin
         slope_in     = $signed({1'b0, half_span_ff}) - $signed({1'b0, trial_x_ff});
         half_span_in = trial_x_ff;
         row_off_in   = trial_y_ff;
         done_in      = (trial_y_ff >= full_hh_ff);
         if (trial_y_ff >= full_hh_ff) begin
            active_in = 1'b0;
         end
      end
   end

   // Next state of the result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_row_in   = out_row_ff;
      out_first_in = out_first_ff;
      out_final_in = out_final_ff;
      out_vis_in   = out_vis_ff;
      out_scale_in = out_scale_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;
      if (cmd.emit != esg_pkg::EMIT_NONE) begin
         out_valid_in = 1'b1;
         out_row_in   = span_vis ? span_row[XW-1:0] : '0;
         out_first_in = span_vis ? first_c[XW-1:0]  : '0;
         out_final_in = span_vis ? final_c[XW-1:0]  : '0;
         out_vis_in   = span_vis;
         out_scale_in = scale_ff;
         out_last_in  = span_last;
         out_done_in  = done_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_mode_ff  <= req_tuser;
         in_cx_ff    <= req_tdata[CW-1:0];
         in_cy_ff    <= req_tdata[2*CW-1:CW];
         in_hw_ff    <= req_tdata[2*CW+IW-1:2*CW];
         in_hh_ff    <= req_tdata[2*CW+2*IW-1:2*CW+IW];
         in_scale_ff <= req_tdata[2*CW+2*IW+SW-1:2*CW+2*IW];
      end
      center_col_in_q: begin end
   end

   always_ff @(posedge clock) begin
      center_col_ff <= center_col_in;
      center_row_ff <= center_row_in;
      full_hw_ff    <= full_hw_in;
      full_hh_ff    <= full_hh_in;
      hsq_ff        <= hsq_in;
      wsq_ff        <= wsq_in;
      bound_ff      <= bound_in;
      tmp_ff        <= tmp_in;
      yterm_ff      <= yterm_in;
      xterm_ff      <= xterm_in;
      row_off_ff    <= row_off_in;
      half_span_ff  <= half_span_in;
      slope_ff      <= slope_in;
      trial_x_ff    <= trial_x_in;
      trial_y_ff    <= trial_y_in;
      scale_ff      <= scale_in;
      done_ff       <= done_in;
      out_row_ff    <= out_row_in;
      out_first_ff  <= out_first_in;
      out_final_ff  <= out_final_in;
      out_vis_ff    <= out_vis_in;
      out_scale_ff  <= out_scale_in;
      out_last_ff   <= out_last_in;
      out_done_ff   <= out_done_in;
   end

   // Status to the sequencer
   assign status.is_start  = (in_mode_ff == esg_pkg::MODE_START);
   assign status.active    = active_ff;
   assign status.x_zero    = (trial_x_ff == '0);
   assign status.test_pass = (test_sum <= {1'b0, bound_ff});
   assign status.out_free  = !out_valid_ff || rsp_tready;

   // Result ports
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(esg_pkg::RSP_TDATA_W - 3*XW - SW){1'b0}},
                        out_scale_ff, out_final_ff, out_first_ff, out_row_ff};
   assign rsp_tuser  = {out_done_ff, out_vis_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

@@ hw/rtl/ellipse_span_generator.sv @@
// Top level of the ellipse span generator: stream ports, screen registers, sequencer and datapath.
//
// Request stream (req_): one transaction per item. req_tuser selects the kind:
// a start latches centre, half-width, half-height (each widened by RADIUS_MARGIN)
// and brightness scale and returns the clipped centre-row span; an advance moves
// one row outward and returns the span above and then the span below the centre.
// An advance with no ellipse in progress returns nothing.
// Response stream (rsp_): one span per transaction; rsp_tlast marks the last span
// of an item, rsp_tuser carries the visibility and ellipse-done flags.
// Items are handled one at a time. A start squares the half-height and half-width
// and multiplies the squares; an advance squares and scales the new row offset,
// then runs a downward search over trial columns; each trial runs one squaring
// and one product through the single shared multiplier and one add-and-compare.
// A finished span waits in the result register while the next item is accepted;
// a stalled receiver only holds the sequencer when a further span is due.
// Reset clears the sequencer, the result register and the active flag, and sets
// the screen size to 800 x 600. Screen size is to be written through the csr_ port
// (register 0 width, register 1 height) while the block is idle; the block does not enforce this.
module ellipse_span_generator #(
   parameter int RADIUS_MARGIN = 5
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request: tdata = center_x[13:0], center_y[27:14], half_width[38:28],
   //          half_height[49:39], brightness_scale[58:50], zero[63:59]
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [esg_pkg::REQ_TDATA_W-1:0]       req_tdata,
   input  logic                                  req_tuser,   // mode[0]
   // Response: tdata = span_row[11:0], span_x_first[23:12], span_x_final[35:24],
   //           span_scale[44:36], zero[47:45]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [esg_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   output logic [esg_pkg::RSP_TUSER_W-1:0]       rsp_tuser,   // span_visible[0], ellipse_done[1]
   output logic                                  rsp_tlast,   // span_last_of_item
   // Configuration
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [esg_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [esg_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [esg_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);

   localparam int XW = esg_pkg::SCREEN_W;

   logic [XW-1:0] screen_width_ff, screen_width_in;
   logic [XW-1:0] screen_height_ff, screen_height_in;
   logic          csr_write;
   logic          csr_index;

   esg_pkg::esg_cmd_type    cmd;
   esg_pkg::esg_status_type status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[2];

   // Register write decode
   always_comb begin
      screen_width_in  = screen_width_ff;
      screen_height_in = screen_height_ff;
      if (csr_write) begin
         case (csr_index)
            esg_pkg::REG_SCREEN_WIDTH:  screen_width_in  = csr_pwdata[XW-1:0];
            esg_pkg::REG_SCREEN_HEIGHT: screen_height_in = csr_pwdata[XW-1:0];
            default: begin
               screen_width_in = screen_width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= esg_pkg::SCREEN_WIDTH_RESET;
         screen_height_ff <= esg_pkg::SCREEN_HEIGHT_RESET;
      end else begin
         screen_width_ff  <= screen_width_in;
         screen_height_ff <= screen_height_in;
      end
   end

   // Register read
   always_comb begin
      case (csr_index)
         esg_pkg::REG_SCREEN_WIDTH:
            csr_prdata = {{(esg_pkg::CSR_DATA_W-XW){1'b0}}, screen_width_ff};
         esg_pkg::REG_SCREEN_HEIGHT:
            csr_prdata = {{(esg_pkg::CSR_DATA_W-XW){1'b0}}, screen_height_ff};
         default:
            csr_prdata = '0;
      endcase
   end

   esg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   esg_datapath #(
      .RADIUS_MARGIN (RADIUS_MARGIN)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .screen_width  (screen_width_ff),
      .screen_height (screen_height_ff),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast)
   );

endmodule

@@ hw/rtl/esg_checker.sv @@
// Port-level assertions of the ellipse span generator and their bind.
module esg_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [esg_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [esg_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);

   // A stalled span holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // One item at a time: an accepted request closes the request side
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while an item is in work");

   // An invisible span carries zero row and columns
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[35:0] == 36'd0)
      else $error("invisible span with nonzero coordinates");

   // A visible span is ordered and its scale is at most one
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[23:12] <= rsp_tdata[35:24]
                                     && rsp_tdata[44:36] <= esg_pkg::SCALE_ONE)
      else $error("visible span out of order or scale above one");

endmodule

bind ellipse_span_generator esg_checker u_esg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
